// ===== sv/pfbe_pkg.sv =====
// Package: shared record types and codes for the block encoder.
`timescale 1ns / 1ps
`default_nettype none
package pfbe_pkg;

   localparam logic [1:0] KIND_HEADER    = 2'd0;
   localparam logic [1:0] KIND_SLOTS     = 2'd1;
   localparam logic [1:0] KIND_EXCEPTION = 2'd2;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [5:0]  bit_width;
      logic [2:0]  exception_count;
      logic [31:0] frame_base;
      logic [31:0] slot_a;
      logic [31:0] slot_b;
      logic [31:0] slot_c;
      logic [31:0] slot_d;
      logic [6:0]  exception_position;
      logic [31:0] exception_value;
      logic        end_of_block;
   } rsp_payload_type;

   // number of significant bits of a 32-bit word, 0 for zero
   function automatic logic [5:0] bit_len(input logic [31:0] v);
      logic [5:0] len;
      len = 6'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) len = 6'(i + 1);
      end
      return len;
   endfunction

endpackage
`default_nettype wire

// ===== sv/pfbe_if.sv =====
// Interfaces: input value channel and output record channel.
`timescale 1ns / 1ps
`default_nettype none
interface pfbe_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        last_value;
   modport source (output valid, output value, output last_value, input ready);
   modport sink (input valid, input value, input last_value, output ready);
endinterface

interface pfbe_rsp_if import pfbe_pkg::*;;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/pfbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pfbe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== sv/pfor_block_encoder_unit.sv =====
// Top level: block collection, min/histogram passes, width pick and record emit.
//
//  channel   dir  signals                     item
//  req_chan  in   valid ready value last      one 32-bit value
//  rsp_chan  out  valid ready data            one header/slot/exception record
//
// Values load one per cycle. Closing a block of n values runs a min pass and
// a histogram pass over the store, a width scan, then reads each slot (four
// per slot record) and scans store entries for exceptions; every record also
// waits for rsp_chan.ready.
// No value is taken until the last record of the block is delivered.
// Synchronous reset empties the block; store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module pfor_block_encoder_unit
   import pfbe_pkg::*;
#(
   parameter int BLOCK_SIZE = 128
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pfbe_req_if.sink   req_chan,
   pfbe_rsp_if.source rsp_chan
);
   localparam int AW   = $clog2(BLOCK_SIZE);
   localparam int CW   = $clog2(BLOCK_SIZE + 1);
   localparam int NREC = (BLOCK_SIZE + 3) / 4;
   localparam int TOT  = 4 * NREC;
   localparam int SW   = $clog2(TOT + 1);

   localparam logic [3:0] S_LOAD = 4'd0;
   localparam logic [3:0] S_MIN  = 4'd1;
   localparam logic [3:0] S_HIST = 4'd2;
   localparam logic [3:0] S_PICK = 4'd3;
   localparam logic [3:0] S_SRD  = 4'd4;
   localparam logic [3:0] S_SCAP = 4'd5;
   localparam logic [3:0] S_XRD  = 4'd6;
   localparam logic [3:0] S_XCHK = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [3:0]      state_ff, state_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic [CW-1:0]   n_ff, n_in;
   logic [CW-1:0]   iss_ff, iss_in;
   logic            pend_ff, pend_in;
   logic [31:0]     base_ff, base_in;
   logic [7:0]      hist_ff [32];
   logic [5:0]      w_ff, w_in;
   logic [7:0]      acc_ff, acc_in;
   logic [5:0]      b_ff, b_in;
   logic [2:0]      nexc_ff, nexc_in;
   logic [2:0]      xcnt_ff, xcnt_in;
   logic [SW-1:0]   sidx_ff, sidx_in;
   logic [AW-1:0]   xidx_ff, xidx_in;
   logic [31:0]     slot_ff [3];
   rsp_payload_type out_ff, out_in;
   logic            outv_ff, outv_in;

   logic            ram_we;
   logic [AW-1:0]   ram_raddr;
   logic [31:0]     ram_rdata;
   logic [31:0]     resid;
   logic [5:0]      rlen;
   logic [7:0]      acc_sum;
   logic            accept;
   logic            closing;
   logic            slot_live;
   logic [31:0]     slot_val;

   pfbe_ram #(.WIDTH(32), .DEPTH(BLOCK_SIZE)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (fill_ff[AW-1:0]),
      .wdata (req_chan.value),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_chan.ready = (state_ff == S_LOAD);
   assign accept  = req_chan.valid && req_chan.ready;
   assign ram_we  = accept;
   assign closing = req_chan.last_value || (fill_ff + 1'b1 == CW'(BLOCK_SIZE));
   assign resid   = ram_rdata - base_ff;
   assign rlen    = bit_len(resid);
   // full-width residuals are not binned; the scan stops at width 32 anyway
   assign acc_sum = acc_ff + hist_ff[w_ff[4:0]];
   assign slot_live = (9'(sidx_ff) < 9'(n_ff)) && (rlen <= b_ff);
   assign slot_val  = slot_live ? resid : 32'd0;

   assign rsp_chan.valid = outv_ff;
   assign rsp_chan.data  = out_ff;

   always_comb begin
      ram_raddr = iss_ff[AW-1:0];
      if (state_ff == S_SRD) ram_raddr = sidx_ff[AW-1:0];
      else if (state_ff == S_XRD) ram_raddr = xidx_ff;
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      n_in     = n_ff;
      iss_in   = iss_ff;
      pend_in  = 1'b0;
      base_in  = base_ff;
      w_in     = w_ff;
      acc_in   = acc_ff;
      b_in     = b_ff;
      nexc_in  = nexc_ff;
      xcnt_in  = xcnt_ff;
      sidx_in  = sidx_ff;
      xidx_in  = xidx_ff;
      out_in   = out_ff;
      outv_in  = outv_ff;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               fill_in = fill_ff + 1'b1;
               if (closing) begin
                  n_in     = fill_ff + 1'b1;
                  fill_in  = '0;
                  base_in  = 32'hFFFF_FFFF;
                  iss_in   = '0;
                  state_in = S_MIN;
               end
            end
         end
         S_MIN, S_HIST: begin
            if (iss_ff < n_ff) begin
               iss_in  = iss_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (state_ff == S_MIN && pend_ff && ram_rdata < base_ff) base_in = ram_rdata;
            if (iss_ff == n_ff && !pend_ff) begin
               iss_in = '0;
               if (state_ff == S_MIN) begin
                  state_in = S_HIST;
               end else begin
                  w_in     = '0;
                  acc_in   = '0;
                  state_in = S_PICK;
               end
            end
         end
         S_PICK: begin
            acc_in = acc_sum;
            w_in   = w_ff + 1'b1;
            // acc >= ceil(95n/100) <=> 100*acc >= 95*n; a hit at width 0 moves on
            // to width 1 so that width-1 residuals are counted as fitting too
            if ((w_ff != 6'd0 && 15'(acc_sum) * 15'd100 >= 15'(n_ff) * 15'd95)
                || w_ff == 6'd32) begin
               b_in    = w_ff;
               nexc_in = (w_ff == 6'd32) ? 3'd0 : 3'(8'(n_ff) - acc_sum);
               out_in  = '0;
               out_in.record_kind     = KIND_HEADER;
               out_in.bit_width       = w_ff;
               out_in.exception_count = (w_ff == 6'd32) ? 3'd0 : 3'(8'(n_ff) - acc_sum);
               out_in.frame_base      = base_ff;
               outv_in  = 1'b1;
               sidx_in  = '0;
               xidx_in  = '0;
               xcnt_in  = '0;
               state_in = S_OUT;
            end
         end
         S_SRD: state_in = S_SCAP;
         S_SCAP: begin
            sidx_in = sidx_ff + 1'b1;
            if (sidx_ff[1:0] == 2'd3) begin
               out_in = '0;
               out_in.record_kind  = KIND_SLOTS;
               out_in.slot_a       = slot_ff[0];
               out_in.slot_b       = slot_ff[1];
               out_in.slot_c       = slot_ff[2];
               out_in.slot_d       = slot_val;
               out_in.end_of_block = (sidx_ff + 1'b1 == SW'(TOT)) && (nexc_ff == 3'd0);
               outv_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_SRD;
            end
         end
         S_XRD: state_in = S_XCHK;
         S_XCHK: begin
            if (rlen > b_ff) begin
               out_in = '0;
               out_in.record_kind        = KIND_EXCEPTION;
               out_in.exception_position = 7'(xidx_ff);
               out_in.exception_value    = resid;
               out_in.end_of_block       = (xcnt_ff + 1'b1 == nexc_ff);
               outv_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               xidx_in  = xidx_ff + 1'b1;
               state_in = S_XRD;
            end
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               outv_in = 1'b0;
               if (out_ff.end_of_block) begin
                  state_in = S_LOAD;
               end else if (out_ff.record_kind == KIND_EXCEPTION) begin
                  xidx_in  = xidx_ff + 1'b1;
                  xcnt_in  = xcnt_ff + 1'b1;
                  state_in = S_XRD;
               end else if (sidx_ff == SW'(TOT)) begin
                  state_in = S_XRD;
               end else begin
                  state_in = S_SRD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
         outv_ff  <= outv_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      iss_ff  <= iss_in;
      base_ff <= base_in;
      w_ff    <= w_in;
      acc_ff  <= acc_in;
      b_ff    <= b_in;
      nexc_ff <= nexc_in;
      xcnt_ff <= xcnt_in;
      sidx_ff <= sidx_in;
      xidx_ff <= xidx_in;
      out_ff  <= out_in;
      if (state_ff == S_SCAP && sidx_ff[1:0] != 2'd3) slot_ff[sidx_ff[1:0]] <= slot_val;
      for (int i = 0; i < 32; i++) begin
         if (state_ff == S_MIN) hist_ff[i] <= 8'd0;
         else if (state_ff == S_HIST && pend_ff && rlen == 6'(i)) hist_ff[i] <= hist_ff[i] + 1'b1;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input taken while a record is pending");
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff < CW'(BLOCK_SIZE))
      else $error("fill count past block size");
   a_header_width: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.data.record_kind == KIND_HEADER |->
      rsp_chan.data.bit_width != 6'd0 && rsp_chan.data.bit_width <= 6'd32)
      else $error("header width out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(out_ff))
      else $error("pending record changed");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/pfor_block_encoder_unit_checker.sv =====
// Checker: watches both channels, predicts the records of each block and compares them.
`timescale 1ns / 1ps
`default_nettype none
module pfor_block_encoder_unit_checker
   import pfbe_pkg::*;
#(
   parameter int BLOCK_SIZE = 128
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_ready,
   input  wire logic [31:0] req_value,
   input  wire logic req_last_value,
   input  wire logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire rsp_payload_type rsp_data,
   output int        mismatch_count,
   output int        records_pending
);

   logic [31:0]     value_copy [BLOCK_SIZE];
   int              fill;
   rsp_payload_type expected_records [$];

   initial begin
      mismatch_count  = 0;
      records_pending = 0;
      fill            = 0;
   end

   always @(posedge clock) begin
      logic [31:0]     resid [BLOCK_SIZE];
      logic [31:0]     base, mask;
      int              hist [33];
      int              need, acc, width, nexc, len, idx;
      rsp_payload_type rec, got;
      if (reset) begin
         fill = 0;
      end else begin
         if (req_valid && req_ready) begin
            value_copy[fill] = req_value;
            fill++;
            if (req_last_value || fill >= BLOCK_SIZE) begin
               base = 32'hFFFF_FFFF;
               for (int i = 0; i < fill; i++)
                  if (value_copy[i] < base) base = value_copy[i];
               for (int w = 0; w <= 32; w++) hist[w] = 0;
               for (int i = 0; i < fill; i++) begin
                  resid[i] = value_copy[i] - base;
                  len = 0;
                  for (int j = 0; j < 32; j++) if (resid[i][j]) len = j + 1;
                  hist[len]++;
               end
               // smallest width covering ceil(95%) of the residuals, never 0
               need  = (fill * 95 + 99) / 100;
               acc   = 0;
               width = 32;
               for (int w = 32; w >= 0; w--) begin
                  acc = 0;
                  for (int v = 0; v <= w; v++) acc += hist[v];
                  if (acc >= need) width = (w == 0) ? 1 : w;
               end
               mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
               nexc = 0;
               for (int i = 0; i < fill; i++) if (resid[i] > mask) nexc++;
               rec                 = '0;
               rec.record_kind     = KIND_HEADER;
               rec.bit_width       = 6'(width);
               rec.exception_count = 3'(nexc);
               rec.frame_base      = base;
               expected_records.push_back(rec);
               for (int k = 0; k < (BLOCK_SIZE + 3) / 4; k++) begin
                  rec             = '0;
                  rec.record_kind = KIND_SLOTS;
                  idx = 4 * k;
                  if (idx     < fill && resid[idx]     <= mask) rec.slot_a = resid[idx];
                  if (idx + 1 < fill && resid[idx + 1] <= mask) rec.slot_b = resid[idx + 1];
                  if (idx + 2 < fill && resid[idx + 2] <= mask) rec.slot_c = resid[idx + 2];
                  if (idx + 3 < fill && resid[idx + 3] <= mask) rec.slot_d = resid[idx + 3];
                  if (nexc == 0 && k == (BLOCK_SIZE + 3) / 4 - 1) rec.end_of_block = 1'b1;
                  expected_records.push_back(rec);
               end
               for (int i = 0; i < fill; i++) begin
                  if (resid[i] > mask) begin
                     rec                    = '0;
                     rec.record_kind        = KIND_EXCEPTION;
                     rec.exception_position = 7'(i);
                     rec.exception_value    = resid[i];
                     nexc--;
                     rec.end_of_block       = (nexc == 0);
                     expected_records.push_back(rec);
                  end
               end
               fill = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_records.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected record: %p", got);
               mismatch_count++;
            end else begin
               rec = expected_records.pop_front();
               if (got.record_kind !== rec.record_kind || got.bit_width !== rec.bit_width
                   || got.exception_count !== rec.exception_count
                   || got.frame_base !== rec.frame_base || got.slot_a !== rec.slot_a
                   || got.slot_b !== rec.slot_b || got.slot_c !== rec.slot_c
                   || got.slot_d !== rec.slot_d
                   || got.exception_position !== rec.exception_position
                   || got.exception_value !== rec.exception_value
                   || got.end_of_block !== rec.end_of_block) begin
                  if (mismatch_count < 10) begin
                     $display("record differs, expected: %p", rec);
                     $display("                 actual: %p", got);
                  end
                  mismatch_count++;
               end
            end
         end
      end
      records_pending = expected_records.size();
   end

endmodule
`default_nettype wire

// ===== tb/sv/pfor_block_encoder_unit_test.sv =====
// Testbench top: clock, reset, value stimulus, record back-pressure and verdict.
`timescale 1ns / 1ps
`default_nettype none
module pfor_block_encoder_unit_test;
   import pfbe_pkg::*;

   localparam int BLOCK_SIZE  = 128;
   localparam int TOTAL_ITEMS = 210;
   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   idle_pct  = 0;
   int   stall_pct = 0;
   int   items_sent = 0;
   int   cycles = 0;
   int   mismatch_count, records_pending;

   pfbe_req_if req_chan ();
   pfbe_rsp_if rsp_chan ();

   pfor_block_encoder_unit #(.BLOCK_SIZE(BLOCK_SIZE)) DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   pfor_block_encoder_unit_checker #(.BLOCK_SIZE(BLOCK_SIZE)) checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .req_value(req_chan.value), .req_last_value(req_chan.last_value),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready), .rsp_data(rsp_chan.data),
      .mismatch_count(mismatch_count), .records_pending(records_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.value      = '0;
      req_chan.last_value = 1'b0;
      rsp_chan.ready      = 1'b0;
   end

   always @(negedge clock) rsp_chan.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("pfor_block_encoder_unit: mismatch");
         $finish;
      end
   end

   // entered and left at a falling edge
   task automatic send_value(input logic [31:0] v, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.value      <= v;
      req_chan.last_value <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_block(input int n, input int outliers, input logic [31:0] base,
                             input int spread_bits);
      logic [31:0] v;
      logic        last;
      for (int i = 0; i < n; i++) begin
         v = base + ($urandom() & ((spread_bits >= 32) ? 32'hFFFF_FFFF
                                                      : ((32'd1 << spread_bits) - 1)));
         if (outliers > 0 && $urandom_range(n - 1 - i) < outliers) begin
            v = base + $urandom();
            outliers--;
         end
         // a full block closes by itself; the flag on its final value may be either
         last = (i == n - 1) ? ((n == BLOCK_SIZE) ? 1'($urandom_range(1)) : 1'b1) : 1'b0;
         send_value(v, last);
      end
   endtask

   task automatic set_phase();
      case ((items_sent * 4) / TOTAL_ITEMS)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 60; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 60; end
         default: begin idle_pct = 24; stall_pct = 24; end
      endcase
   endtask

   initial begin
      int n, roll, left;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: all-zero residuals, full range, single values, mixed base
      send_value(32'h0000_0000, 1'b1);
      send_value(32'hFFFF_FFFF, 1'b1);
      send_value(32'hFFFF_FFFF, 1'b0);
      send_value(32'hFFFF_FFFF, 1'b1);
      send_value(32'h0000_0000, 1'b0);
      send_value(32'hFFFF_FFFF, 1'b1);
      send_value(32'h8000_0001, 1'b0);
      send_value(32'h7FFF_FFFE, 1'b0);
      send_value(32'h5555_5555, 1'b0);
      send_value(32'hAAAA_AAAA, 1'b1);
      send_block(12, 0, 32'h1234_5678, 4);
      // everything drains before the random part starts
      while (records_pending != 0) @(negedge clock);
      while (items_sent < TOTAL_ITEMS) begin
         set_phase();
         left = TOTAL_ITEMS - items_sent;
         roll = $urandom_range(9);
         if (roll == 0 && left >= BLOCK_SIZE)
            send_block(BLOCK_SIZE, $urandom_range(8), $urandom(), $urandom_range(1, 12));
         else if (roll < 5) begin
            n = $urandom_range(20, 48);
            if (n > left) n = left;
            send_block(n, $urandom_range(3), $urandom(), $urandom_range(0, 10));
         end else begin
            n = $urandom_range(1, 19);
            if (n > left) n = left;
            send_block(n, $urandom_range(2), $urandom(), $urandom_range(0, 32));
         end
      end
      req_chan.valid <= 1'b0;
      while (records_pending != 0) @(negedge clock);
      repeat (400) @(posedge clock);
      if (mismatch_count == 0 && records_pending == 0)
         $display("pfor_block_encoder_unit: match");
      else
         $display("pfor_block_encoder_unit: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
